>>> hw/rtl/stas_pkg.sv
// ----------------------------------------------------------------------------
// stas_pkg: shared types, constants and tap table
// Constants, state codes and the delay tap table of the ambience summer.
// ----------------------------------------------------------------------------
package stas_pkg;

    localparam int SampleWidth  = 24;
    localparam int HistoryDepth = 16384;
    localparam int HistAw       = 14;
    localparam int GroupCount   = 33;
    localparam int TapTotal     = 657;
    localparam int TapAw        = 10;
    localparam int FirstGroupTaps = 17;
    localparam int GroupTaps    = 20;
    localparam int AccWidth     = 45;
    localparam int ProdWidth    = AccWidth + 18;

    localparam logic [1:0] CfgWetGain    = 2'd0;
    localparam logic [1:0] CfgTapGroups  = 2'd1;
    localparam logic [1:0] CfgDecayRecip = 2'd2;

    localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE, ST_DECAY, ST_DECAY_SAT, ST_READ,
        ST_ADD, ST_MIX_A, ST_MIX_B, ST_OUT
    } stas_state_t;

    localparam logic [13:0] TapDelay [TapTotal] = '{
    313,289,271,239,223,209,191,181,151,143,121,109,73,47,41,19,11,
    643,619,613,601,593,577,557,529,521,503,491,463,457,421,407,389,379,361,341,331,
    1009,991,971,961,947,923,913,899,869,857,829,811,803,793,767,727,713,691,671,653,
    1373,1357,1343,1331,1319,1291,1279,1271,1249,1241,1217,1187,1147,1121,1109,1087,1067,1051,
    1037,1019,
    1777,1747,1711,1693,1679,1657,1639,1633,1609,1579,1549,1523,1513,1501,1483,1469,1451,1439,
    1427,1403,
    2153,2129,2117,2083,2069,2047,2039,2027,2011,1969,1951,1919,1909,1891,1871,1847,1837,1819,
    1807,1787,
    2533,2509,2497,2479,2459,2441,2431,2419,2377,2353,2341,2329,2299,2293,2267,2251,2239,2227,
    2183,2167,
    2963,2957,2911,2897,2879,2861,2837,2801,2777,2767,2731,2707,2683,2671,2663,2647,2623,2603,
    2579,2563,
    3299,3289,3281,3253,3229,3221,3191,3167,3151,3139,3121,3113,3103,3083,3067,3043,3013,3007,
    2993,2981,
    3677,3667,3653,3631,3613,3593,3581,3559,3553,3523,3503,3469,3457,3443,3431,3419,3391,3377,
    3341,3329,
    4033,4009,4001,3979,3961,3937,3919,3893,3877,3851,3833,3821,3799,3791,3769,3757,3733,3721,
    3707,3691,
    4399,4367,4357,4343,4331,4307,4289,4279,4243,4223,4213,4187,4181,4159,4147,4133,4103,4097,
    4087,4073,
    4813,4799,4777,4757,4733,4703,4679,4657,4643,4631,4601,4591,4577,4547,4517,4507,4489,4471,
    4439,4421,
    5179,5147,5113,5101,5087,5081,5059,5053,5021,5009,4979,4961,4939,4931,4903,4891,4877,4871,
    4861,4849,
    5611,5599,5587,5569,5549,5521,5503,5483,5461,5429,5401,5377,5353,5333,5323,5267,5261,5237,
    5213,5191,
    5959,5947,5933,5921,5911,5897,5879,5849,5833,5813,5807,5773,5743,5737,5729,5717,5699,5669,
    5641,5627,
    6353,6329,6317,6301,6281,6263,6253,6233,6197,6163,6137,6127,6109,6077,6067,6049,6031,6011,
    6001,5977,
    6707,6677,6653,6641,6623,6607,6581,6563,6553,6539,6511,6499,6487,6469,6457,6449,6439,6413,
    6397,6373,
    7069,7061,7039,6997,6983,6971,6953,6941,6919,6913,6907,6859,6847,6829,6823,6809,6787,6763,
    6749,6731,
    7481,7447,7429,7409,7397,7369,7363,7319,7291,7277,7267,7249,7243,7237,7187,7171,7151,7117,
    7099,7087,
    7879,7871,7841,7831,7813,7799,7783,7747,7733,7709,7673,7661,7633,7627,7607,7597,7561,7543,
    7529,7513,
    8287,8273,8233,8221,8209,8201,8173,8161,8143,8117,8107,8083,8069,8059,8023,8009,7991,7943,
    7927,7909,
    8669,8657,8647,8623,8599,8581,8569,8563,8539,8521,8507,8497,8473,8437,8411,8387,8371,8363,
    8339,8303,
    9089,9071,9043,9019,9007,8971,8963,8929,8917,8893,8863,8849,8837,8803,8779,8761,8753,8731,
    8699,8677,
    9433,9413,9403,9391,9371,9349,9323,9311,9301,9277,9257,9239,9227,9221,9169,9161,9151,9137,
    9109,9101,
    9851,9817,9773,9763,9721,9703,9697,9673,9641,9631,9619,9607,9581,9559,9547,9521,9493,9487,
    9469,9449,
    10321,10301,10261,10253,10231,10211,10189,10159,10139,10099,10093,10079,10039,9983,9973,
    9953,9929,9911,9893,9871,
    10669,10657,10649,10637,10621,10609,10603,10597,10571,10561,10553,10499,10481,10453,10439,
    10417,10399,10391,10363,10343,
    11099,11071,11047,11033,11021,10993,10973,10943,10933,10919,10897,10879,10867,10841,10783,
    10763,10751,10733,10721,10687,
    11467,11441,11413,11399,11363,11353,11329,11323,11303,11293,11281,11251,11231,11209,11201,
    11177,11171,11153,11141,11117,
    11897,11873,11843,11819,11791,11773,11731,11723,11701,11687,11659,11623,11611,11587,11573,
    11549,11537,11527,11513,11503,
    12281,12247,12239,12203,12197,12191,12163,12143,12127,12109,12083,12077,12059,12037,11989,
    11969,11951,11933,11927,11911,
    12679,12671,12661,12613,12587,12577,12563,12557,12521,12499,12493,12457,12427,12401,12373,
    12367,12349,12337,12323,12301
    };

    // First tap index of a group
    function automatic logic [TapAw-1:0] group_start(input logic [5:0] g);
        logic [TapAw-1:0] s;
        if (g == 6'd0)
            s = '0;
        else
            s = TapAw'(FirstGroupTaps) + TapAw'({g - 6'd1, 4'b0})
                + TapAw'({g - 6'd1, 2'b0});
        return s;
    endfunction

    function automatic logic signed [AccWidth-1:0] sat_acc(
        input logic signed [ProdWidth-1:0] v);
        logic signed [AccWidth-1:0] r;
        if (v > ProdWidth'(AccMax))
            r = AccMax;
        else if (v < ProdWidth'(AccMin))
            r = AccMin;
        else
            r = v[AccWidth-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/stas_stream_if.sv
// ----------------------------------------------------------------------------
// stas_stream_if: valid/ready channel
// Carries one payload of a given width between a source and a sink.
// ----------------------------------------------------------------------------
interface stas_stream_if #(parameter int Width = 24);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/sparse_tap_ambience_sum.sv
// ----------------------------------------------------------------------------
// sparse_tap_ambience_sum: sparse-tap ambience summer
// Stores each sample in a 16384-entry history and mixes a decayed tap sum.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass zeroes the history,
// during which no sample is taken. Per item: one history write, then per
// group the decay states (ST_DECAY, ST_DECAY_SAT) and one history read per
// tap (read, then add), then the mix states ST_MIX_A and ST_MIX_B and a load
// into the output register. A stalled receiver holds the input only once a
// second result is ready. The per-tap read and add make up most of the work
// of an item, from one input transfer to the next.
module sparse_tap_ambience_sum
    import stas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [16:0]            cfg_data,
    stas_stream_if.sink            in_ch,
    stas_stream_if.source          out_ch
);
    stas_state_t state_reg, state_next;
    logic [16:0] wet_reg, decay_reg;
    logic [5:0]  groups_reg;
    logic [HistAw-1:0] wpos_reg, clr_reg;
    logic [5:0]  grp_reg, grp_next;
    logic [TapAw-1:0] tap_reg, tap_next, tap_end;
    logic signed [AccWidth-1:0] acc_reg, acc_next;
    logic signed [ProdWidth-1:0] prod_reg;
    logic signed [SampleWidth-1:0] dry_reg, out_reg, mix;
    logic clip_reg, clip;
    logic out_valid_reg, out_free;
    logic we;
    logic [HistAw-1:0] addr;
    logic [SampleWidth-1:0] wdata, rdata;
    logic signed [ProdWidth-1:0] prod_tr;

    stas_ram #(.Width(SampleWidth), .Depth(HistoryDepth)) u_hist (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    stas_mixer u_mix (
        .clk(clk), .stage_a(state_reg == ST_MIX_A), .dry(dry_reg),
        .acc(acc_reg), .wet_gain(wet_reg), .mix(mix), .clip(clip)
    );

    assign tap_end = (grp_reg == 6'd0) ? TapAw'(FirstGroupTaps - 1)
                                       : group_start(grp_reg) + TapAw'(GroupTaps - 1);
    assign prod_tr = (prod_reg < 0) ? -((-prod_reg) >>> 16) : (prod_reg >>> 16);

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {clip_reg, out_reg};

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        tap_next   = tap_reg;
        acc_next   = acc_reg;
        we         = 1'b0;
        addr       = wpos_reg + TapDelay[tap_reg];
        wdata      = dry_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = '0;
                if (clr_reg == HistAw'(HistoryDepth - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_ch.valid)
                    state_next = ST_WRITE;
            ST_WRITE:
            begin
                we         = 1'b1;
                addr       = wpos_reg;
                acc_next   = '0;
                grp_next   = (groups_reg > 6'(GroupCount - 1)) ? 6'(GroupCount - 1)
                                                               : groups_reg;
                state_next = ST_DECAY;
            end
            ST_DECAY:
                state_next = ST_DECAY_SAT;
            ST_DECAY_SAT:
            begin
                acc_next   = sat_acc(prod_tr);
                tap_next   = group_start(grp_reg);
                state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_ADD;
            ST_ADD:
            begin
                acc_next = sat_acc(ProdWidth'(acc_reg) + ProdWidth'($signed(rdata)));
                tap_next = tap_reg + 1'b1;
                if (tap_reg != tap_end)
                    state_next = ST_READ;
                else if (grp_reg != 6'd0)
                begin
                    grp_next   = grp_reg - 1'b1;
                    state_next = ST_DECAY;
                end
                else
                    state_next = ST_MIX_A;
            end
            ST_MIX_A:
                state_next = ST_MIX_B;
            ST_MIX_B:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            wet_reg       <= 17'd65536;
            groups_reg    <= 6'd32;
            decay_reg     <= 17'd65536;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_OUT && out_free)
            begin
                wpos_reg      <= wpos_reg - 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CfgWetGain:    wet_reg    <= cfg_data;
                    CfgTapGroups:  groups_reg <= cfg_data[5:0];
                    CfgDecayRecip: decay_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        tap_reg  <= tap_next;
        acc_reg  <= acc_next;
        prod_reg <= ProdWidth'(acc_reg) * ProdWidth'($signed({1'b0, decay_reg}));
        if (in_ch.valid && in_ch.ready)
            dry_reg <= in_ch.data;
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg  <= mix;
            clip_reg <= clip;
        end
    end

    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input ready outside idle");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result changed while stalled");
    a_wpos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (wpos_reg == $past(wpos_reg) - 1'b1))
        else $error("write position did not advance");
endmodule

>>> hw/rtl/stas_ram.sv
// ----------------------------------------------------------------------------
// stas_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module stas_ram #(
    parameter int Width = 24,
    parameter int Depth = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/stas_mixer.sv
// ----------------------------------------------------------------------------
// stas_mixer: dry/wet mix and saturation
// Products registered, then sum, scale and clamp.
// ----------------------------------------------------------------------------
module stas_mixer
    import stas_pkg::*;
(
    input  logic                          clk,
    input  logic                          stage_a,
    input  logic signed [SampleWidth-1:0] dry,
    input  logic signed [AccWidth-1:0]    acc,
    input  logic [16:0]                   wet_gain,
    output logic signed [SampleWidth-1:0] mix,
    output logic                          clip
);
    localparam int TotW = AccWidth + 20;

    logic signed [TotW-1:0] dry_prod_reg, wet_prod_reg;
    logic signed [TotW-1:0] total, scaled;
    logic signed [18:0]     dry_gain;

    assign dry_gain = 19'sd65536 - $signed({2'b0, wet_gain});

    // register both products, hold them until the next item
    always_ff @(posedge clk)
    begin
        if (stage_a)
        begin
            dry_prod_reg <= TotW'($signed({dry, 2'b0})) * TotW'(dry_gain);
            wet_prod_reg <= TotW'(acc) * TotW'($signed({1'b0, wet_gain}));
        end
    end

    always_comb
    begin
        total  = dry_prod_reg + wet_prod_reg;
        // truncate toward zero
        scaled = (total < 0) ? -((-total) >>> 18) : (total >>> 18);
        clip   = 1'b0;
        if (scaled > $signed(TotW'({1'b0, {(SampleWidth-1){1'b1}}})))
        begin
            mix  = {1'b0, {(SampleWidth-1){1'b1}}};
            clip = 1'b1;
        end
        else if (scaled < -$signed(TotW'({1'b1, {(SampleWidth-1){1'b0}}})))
        begin
            mix  = {1'b1, {(SampleWidth-1){1'b0}}};
            clip = 1'b1;
        end
        else
            mix = scaled[SampleWidth-1:0];
    end
endmodule
